/* src/pps_pkg.sv */
// Shared types and constants for the pose path sampler.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int T_FRAC_DEF      = 16;
  localparam int COUNT_WIDTH     = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RUN
  } pps_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic issue;
  } pps_cmd_t;

  typedef struct packed {
    logic adv;
    logic single_req;
    logic last_issue;
  } pps_status_t;

endpackage

/* src/pps_ctrl.sv */
// Controller state machine that sequences the step division and the pose issue.
`timescale 1ns / 1ps

module pps_ctrl #(
  parameter int T_FRAC_BITS = pps_pkg::T_FRAC_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  pps_pkg::pps_status_t status_i,
  output pps_pkg::pps_cmd_t    cmd_o
);
  import pps_pkg::*;

  localparam int CNT_W = $clog2(T_FRAC_BITS + 1);

  pps_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             div_done;

  assign div_done = (cnt_q == CNT_W'(T_FRAC_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = status_i.single_req ? ST_RUN : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.adv && status_i.last_issue) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o    = 1'b0;
    cmd_o          = '0;
    cnt_d          = cnt_q;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
        cnt_d       = '0;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      ST_RUN: begin
        cmd_o.issue = status_i.adv;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

endmodule

/* src/pps_datapath.sv */
// Datapath with request registers, step divider, parameter generator and blend pipeline.
`timescale 1ns / 1ps

module pps_datapath #(
  parameter int MAX_POINTS  = pps_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = pps_pkg::T_FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pps_pkg::pps_cmd_t                   cmd_i,
  output pps_pkg::pps_status_t                status_o,
  input  logic                                req_type_i,
  input  logic signed [COORD_WIDTH-1:0]       start_x_i,
  input  logic signed [COORD_WIDTH-1:0]       start_y_i,
  input  logic signed [COORD_WIDTH-1:0]       start_heading_i,
  input  logic signed [COORD_WIDTH-1:0]       ctrl_x_i,
  input  logic signed [COORD_WIDTH-1:0]       ctrl_y_i,
  input  logic signed [COORD_WIDTH-1:0]       end_x_i,
  input  logic signed [COORD_WIDTH-1:0]       end_y_i,
  input  logic signed [COORD_WIDTH-1:0]       end_heading_i,
  input  logic [pps_pkg::COUNT_WIDTH-1:0]     point_count_i,
  input  logic                                pose_ready_i,
  output logic                                pose_valid_o,
  output logic signed [COORD_WIDTH-1:0]       pose_x_o,
  output logic signed [COORD_WIDTH-1:0]       pose_y_o,
  output logic signed [COORD_WIDTH-1:0]       pose_heading_o,
  output logic                                last_point_o
);
  import pps_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int PROD_W = COORD_WIDTH + T_FRAC_BITS + 3;

  // A blend written as a + round((b - a) * t), which equals the two-product form exactly.
  function automatic logic signed [COORD_WIDTH-1:0] lerp(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b,
    input logic [T_W-1:0]                t
  );
    logic signed [COORD_WIDTH:0]   diff;
    logic signed [T_W:0]           ts;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rnd;
    logic signed [COORD_WIDTH:0]   delta;
    logic signed [COORD_WIDTH:0]   sum;
    diff  = (COORD_WIDTH + 1)'(b) - (COORD_WIDTH + 1)'(a);
    ts    = signed'({1'b0, t});
    prod  = PROD_W'(diff) * PROD_W'(ts);
    rnd   = prod + (PROD_W'(1) <<< (T_FRAC_BITS - 1));
    delta = (COORD_WIDTH + 1)'(rnd >>> T_FRAC_BITS);
    sum   = (COORD_WIDTH + 1)'(a) + delta;
    return sum[COORD_WIDTH-1:0];
  endfunction

  logic                          mode_q;
  logic signed [COORD_WIDTH-1:0] sx_q, sy_q, sh_q, cx_q, cy_q, ex_q, ey_q, eh_q;
  logic [IDX_W-1:0]              nm1_q;
  logic [T_W-1:0]                qd_q;
  logic [IDX_W-1:0]              rem_q;
  logic [IDX_W-1:0]              k_q;
  logic [T_W-1:0]                t_q;
  logic [IDX_W-1:0]              acc_q;

  logic [COUNT_WIDTH-1:0]        n_clamped;
  logic [COUNT_WIDTH-1:0]        nm1_full;
  logic [IDX_W:0]                rem_sh, rem_sub;
  logic                          div_ge;
  logic [IDX_W:0]                acc_sum, acc_sub;
  logic                          carry;
  logic [IDX_W-1:0]              acc_next;
  logic [T_W-1:0]                t_next;
  logic                          adv;
  logic                          last_issue;

  logic                          a_valid_q;
  logic signed [COORD_WIDTH-1:0] ax_q, ay_q, bx_q, by_q, ah_q;
  logic [T_W-1:0]                ta_q;
  logic                          last_a_q;

  logic                          out_valid_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q, ph_q;
  logic                          last_q;

  always_comb begin
    if (point_count_i == '0) begin
      n_clamped = COUNT_WIDTH'(1);
    end else if (point_count_i > COUNT_WIDTH'(MAX_POINTS)) begin
      n_clamped = COUNT_WIDTH'(MAX_POINTS);
    end else begin
      n_clamped = point_count_i;
    end
  end

  assign nm1_full = n_clamped - 1'b1;

  assign rem_sh  = {rem_q, qd_q[T_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, nm1_q});
  assign rem_sub = rem_sh - {1'b0, nm1_q};

  assign acc_sum  = {1'b0, acc_q} + {1'b0, rem_q};
  assign carry    = (acc_sum >= {1'b0, nm1_q});
  assign acc_sub  = acc_sum - {1'b0, nm1_q};
  assign acc_next = carry ? acc_sub[IDX_W-1:0] : acc_sum[IDX_W-1:0];
  assign t_next   = t_q + qd_q + T_W'(carry);

  assign adv        = !out_valid_q || pose_ready_i;
  assign last_issue = (k_q == nm1_q);

  assign status_o.adv        = adv;
  assign status_o.single_req = (n_clamped == COUNT_WIDTH'(1));
  assign status_o.last_issue = last_issue;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      sh_q <= start_heading_i;
      cx_q <= ctrl_x_i;
      cy_q <= ctrl_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
      eh_q <= end_heading_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      nm1_q  <= '0;
      qd_q   <= '0;
      rem_q  <= '0;
      k_q    <= '0;
      t_q    <= '0;
      acc_q  <= '0;
    end else if (cmd_i.load) begin
      mode_q <= req_type_i;
      nm1_q  <= nm1_full[IDX_W-1:0];
      qd_q   <= T_W'(1) << T_FRAC_BITS;
      rem_q  <= '0;
      k_q    <= '0;
      t_q    <= '0;
      acc_q  <= '0;
    end else if (cmd_i.div_step) begin
      qd_q  <= {qd_q[T_W-2:0], div_ge};
      rem_q <= div_ge ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];
    end else if (cmd_i.issue) begin
      k_q   <= k_q + 1'b1;
      t_q   <= t_next;
      acc_q <= acc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= cmd_i.issue;
      out_valid_q <= a_valid_q;
    end
  end

  // In straight mode both first-level blends equal the start-to-end blend, so the
  // second level returns it unchanged.
  always_ff @(posedge clk_i) begin
    if (adv && cmd_i.issue) begin
      ax_q     <= lerp(sx_q, mode_q ? cx_q : ex_q, t_q);
      ay_q     <= lerp(sy_q, mode_q ? cy_q : ey_q, t_q);
      bx_q     <= lerp(mode_q ? cx_q : sx_q, ex_q, t_q);
      by_q     <= lerp(mode_q ? cy_q : sy_q, ey_q, t_q);
      ah_q     <= lerp(sh_q, eh_q, t_q);
      ta_q     <= t_q;
      last_a_q <= last_issue;
    end
    if (adv && a_valid_q) begin
      px_q   <= lerp(ax_q, bx_q, ta_q);
      py_q   <= lerp(ay_q, by_q, ta_q);
      ph_q   <= ah_q;
      last_q <= last_a_q;
    end
  end

  assign pose_valid_o   = out_valid_q;
  assign pose_x_o       = px_q;
  assign pose_y_o       = py_q;
  assign pose_heading_o = ph_q;
  assign last_point_o   = last_q;

endmodule

/* src/pose_path_sampler.sv */
// Top level of the pose path sampler: controller and datapath.
// Flow: a request is accepted in idle; the serial step division follows (skipped for a single
// pose), and each issued pose passes the blend stage register and then the output register.
// Throughput: one pose per cycle once issue runs, while the output is not stalled; the block
// returns to idle after the last issue and can take a new request while that tail drains.
// The step divider is serial and the blend pipeline has two stages.
// Reset is asynchronous and active low; it empties the pipeline and returns to idle.
`timescale 1ns / 1ps

module pose_path_sampler #(
  parameter int MAX_POINTS  = pps_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = pps_pkg::T_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic                            req_type_i,
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   start_heading_i,
  input  logic signed [COORD_WIDTH-1:0]   ctrl_x_i,
  input  logic signed [COORD_WIDTH-1:0]   ctrl_y_i,
  input  logic signed [COORD_WIDTH-1:0]   end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   end_y_i,
  input  logic signed [COORD_WIDTH-1:0]   end_heading_i,
  input  logic [pps_pkg::COUNT_WIDTH-1:0] point_count_i,
  output logic                            pose_valid_o,
  input  logic                            pose_ready_i,
  output logic signed [COORD_WIDTH-1:0]   pose_x_o,
  output logic signed [COORD_WIDTH-1:0]   pose_y_o,
  output logic signed [COORD_WIDTH-1:0]   pose_heading_o,
  output logic                            last_point_o
);
  import pps_pkg::*;

  pps_cmd_t    cmd;
  pps_status_t status;

  pps_ctrl #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (req_type_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .start_heading_i(start_heading_i),
    .ctrl_x_i       (ctrl_x_i),
    .ctrl_y_i       (ctrl_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .end_heading_i  (end_heading_i),
    .point_count_i  (point_count_i),
    .pose_ready_i   (pose_ready_i),
    .pose_valid_o   (pose_valid_o),
    .pose_x_o       (pose_x_o),
    .pose_y_o       (pose_y_o),
    .pose_heading_o (pose_heading_o),
    .last_point_o   (last_point_o)
  );

endmodule

/* src/pps_checker.sv */
// Port-level checker for the pose path sampler and its bind statement.
`timescale 1ns / 1ps

module pps_checker #(
  parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_o,
  input logic                          pose_valid_o,
  input logic                          pose_ready_i,
  input logic signed [COORD_WIDTH-1:0] pose_x_o,
  input logic signed [COORD_WIDTH-1:0] pose_y_o,
  input logic signed [COORD_WIDTH-1:0] pose_heading_o,
  input logic                          last_point_o
);

  logic [1:0] pending_q, pending_d;
  logic       req_acc, last_acc;

  assign req_acc  = req_valid_i && req_ready_o;
  assign last_acc = pose_valid_o && pose_ready_i && last_point_o;

  always_comb begin
    pending_d = pending_q;
    if (req_acc && !last_acc) begin
      pending_d = pending_q + 1'b1;
    end else if (!req_acc && last_acc) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled word keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pose_valid_o && !pose_ready_i) |=> (pose_valid_o && $stable(pose_x_o) &&
      $stable(pose_y_o) && $stable(pose_heading_o) && $stable(last_point_o)))
    else $error("pose word changed while stalled");

  a_req_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_o)
    else $error("request ready right after an accepted request");

  a_last_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |-> (pending_q != 2'd0))
    else $error("final pose without an open request");

  // The two pipeline stages can each hold the tail of an earlier request.
  a_overlap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> (pending_q != 2'd3))
    else $error("more than three requests in flight");

endmodule

bind pose_path_sampler pps_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pps_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the pose path sampler with random requests, stalls and drains.
`timescale 1ns / 1ps

module testbench;
  import pps_pkg::*;

  localparam int CW            = COORD_WIDTH_DEF;
  localparam int TF            = T_FRAC_DEF;
  localparam int MAXP          = MAX_POINTS_DEF;
  localparam int NUM_RANDOM    = 210;
  localparam int CALM_TAIL     = 25;
  localparam int HOLD_AT       = 50;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 1200000;

  localparam logic MODE_LINE   = 1'b0;
  localparam logic MODE_BEZIER = 1'b1;

  localparam int SX = 0, SY = 1, SH = 2, CX = 3, CY = 4, EX = 5, EY = 6, EH = 7;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam longint ONE  = longint'(1) << TF;
  localparam longint HALF = longint'(1) << (TF - 1);

  typedef logic [0:7][CW-1:0] coord_set_t;

  typedef struct {
    logic                   mode;
    coord_set_t             coord;
    logic [COUNT_WIDTH-1:0] count;
    bit                     drain_first;
  } path_req_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] h;
    logic                 last;
  } pose_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   req_valid   = 1'b0;
  logic                   req_ready;
  logic                   req_type    = MODE_LINE;
  coord_set_t             req_coord   = '0;
  logic [COUNT_WIDTH-1:0] point_count = COUNT_WIDTH'(1);

  logic                 pose_valid;
  logic                 pose_ready = 1'b0;
  logic signed [CW-1:0] pose_x;
  logic signed [CW-1:0] pose_y;
  logic signed [CW-1:0] pose_h;
  logic                 pose_last;

  path_req_t pending_paths[$];
  pose_t     expected_poses[$];
  path_req_t cur_path;

  int  total_paths    = 0;
  int  n_accepted     = 0;
  int  n_poses        = 0;
  int  fail_cnt       = 0;
  int  cycle_cnt      = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  expected_empty = 1'b1;
  bit  offering       = 1'b0;
  int  tx_gap         = 0;
  int  tx_quiet       = 0;
  int  rx_stall       = 0;
  int  rx_quiet       = 0;

  pose_path_sampler u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_valid),
    .req_ready_o     (req_ready),
    .req_type_i      (req_type),
    .start_x_i       (req_coord[SX]),
    .start_y_i       (req_coord[SY]),
    .start_heading_i (req_coord[SH]),
    .ctrl_x_i        (req_coord[CX]),
    .ctrl_y_i        (req_coord[CY]),
    .end_x_i         (req_coord[EX]),
    .end_y_i         (req_coord[EY]),
    .end_heading_i   (req_coord[EH]),
    .point_count_i   (point_count),
    .pose_valid_o    (pose_valid),
    .pose_ready_i    (pose_ready),
    .pose_x_o        (pose_x),
    .pose_y_o        (pose_y),
    .pose_heading_o  (pose_h),
    .last_point_o    (pose_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint blend(longint a, longint b, longint t);
    return (a * (ONE - t) + b * t + HALF) >>> TF;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic void append_pose(pose_t p);
    expected_poses.insert(expected_poses.size(), p);
  endfunction

  function automatic void append_path(path_req_t r);
    pending_paths.insert(pending_paths.size(), r);
  endfunction

  function automatic void predict_poses(path_req_t r);
    int     n;
    int     k;
    int     i;
    longint t;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint px;
    longint py;
    longint c [8];
    pose_t  p;
    n = int'(r.count);
    if (n == 0) n = 1;
    if (n > MAXP) n = MAXP;
    for (i = 0; i < 8; i++) c[i] = longint'($signed(r.coord[i]));
    for (k = 0; k < n; k++) begin
      t = (n > 1) ? (longint'(k) << TF) / (n - 1) : 0;
      if (r.mode == MODE_BEZIER) begin
        ax = blend(c[SX], c[CX], t);
        ay = blend(c[SY], c[CY], t);
        bx = blend(c[CX], c[EX], t);
        by = blend(c[CY], c[EY], t);
        px = blend(ax, bx, t);
        py = blend(ay, by, t);
      end else begin
        px = blend(c[SX], c[EX], t);
        py = blend(c[SY], c[EY], t);
      end
      p.x    = clamp_coord(px);
      p.y    = clamp_coord(py);
      p.h    = clamp_coord(blend(c[SH], c[EH], t));
      p.last = (k == n - 1);
      append_pose(p);
    end
  endfunction

  function automatic void add_path(logic mode, int count, coord_set_t c);
    path_req_t r;
    r.mode        = mode;
    r.coord       = c;
    r.count       = COUNT_WIDTH'(count);
    r.drain_first = 1'b0;
    append_path(r);
  endfunction

  function automatic logic [CW-1:0] random_coord();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 7))
      0: raw = CMAX;
      1: raw = CMIN;
      2, 3: raw = $urandom_range(0, 4000) - 2000;
      default: ;
    endcase
    return raw[CW-1:0];
  endfunction

  function automatic path_req_t random_path();
    path_req_t r;
    int        i;
    int        pick;
    r.mode = 1'($urandom_range(0, 1));
    for (i = 0; i < 8; i++) r.coord[i] = random_coord();
    if ($urandom_range(0, 9) == 0) begin
      r.coord[EX] = r.coord[SX];
      r.coord[EY] = r.coord[SY];
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) r.count = COUNT_WIDTH'($urandom_range(1, 10));
    else if (pick < 88) r.count = COUNT_WIDTH'($urandom_range(11, 40));
    else if (pick < 95) r.count = COUNT_WIDTH'($urandom_range(41, 64));
    else if (pick < 97) r.count = '0;
    else r.count = COUNT_WIDTH'($urandom_range(65, 127));
    r.drain_first = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at pose %0d: %s got %0d expected %0d", n_poses, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    bit accepted_now;
    bit calm;
    accepted_now = 1'b0;
    if (rst_n) begin
      accepted_now = req_valid && req_ready;
      calm = (n_accepted >= total_paths - CALM_TAIL);
      if (accepted_now) begin
        offering = 1'b0;
        if (tx_quiet > 0) tx_quiet--;
        else if (!calm && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 16);
        else if ($urandom_range(0, 9) == 0) tx_quiet = $urandom_range(4, 12);
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_paths.size() > 0 &&
                     (!pending_paths[0].drain_first || (expected_empty && !accepted_now))) begin
          cur_path = pending_paths.pop_front();
          offering = 1'b1;
        end
      end
    end
    req_valid   <= offering;
    req_type    <= cur_path.mode;
    req_coord   <= cur_path.coord;
    point_count <= cur_path.count;
  end

  always @(posedge clk) begin
    path_req_t seen;
    pose_t     want;
    bit        ready_next;
    ready_next = 1'b0;
    if (rst_n) begin
      if (req_valid && req_ready) begin
        seen.mode        = req_type;
        seen.coord       = req_coord;
        seen.count       = point_count;
        seen.drain_first = 1'b0;
        predict_poses(seen);
        n_accepted <= n_accepted + 1;
      end
      if (pose_valid && pose_ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("pose with nothing expected", pose_x, 0);
        end else begin
          want = expected_poses.pop_front();
          if (pose_x !== want.x) report_mismatch("pose_x", pose_x, want.x);
          if (pose_y !== want.y) report_mismatch("pose_y", pose_y, want.y);
          if (pose_h !== want.h) report_mismatch("pose_heading", pose_h, want.h);
          if (pose_last !== want.last) report_mismatch("last_point", pose_last, want.last);
        end
        n_poses++;
      end
      if (n_accepted >= total_paths - CALM_TAIL) begin
        ready_next = 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else if (rx_quiet > 0) begin
        rx_quiet--;
        ready_next = 1'b1;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2: rx_stall = $urandom_range(0, 15);
          3: begin
            rx_quiet   = $urandom_range(20, 120);
            ready_next = 1'b1;
          end
          default: ready_next = 1'b1;
        endcase
      end
      ready_next = ready_next && (hold_left == 0);
    end
    expected_empty <= (expected_poses.size() == 0);
    pose_ready     <= ready_next;
  end

  // The receiver blocks once for a long stretch so the block backs up onto its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    path_req_t r;
    int        i;
    cur_path = '{mode: MODE_LINE, coord: '0, count: 1, drain_first: 1'b0};

    add_path(MODE_LINE,   1,   '{0, 0, 0, 0, 0, 0, 0, 0});
    add_path(MODE_LINE,   0,   '{1000, -2000, 300, 5, 5, -7000, 8000, -900});
    add_path(MODE_LINE,   2,   '{CMIN, CMAX, CMIN, 0, 0, CMAX, CMIN, CMAX});
    add_path(MODE_LINE,   3,   '{0, 0, 0, 0, 0, 1, -1, 1});
    add_path(MODE_LINE,   127, '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN});
    add_path(MODE_BEZIER, 64,  '{CMIN, CMAX, 0, CMAX, CMIN, CMIN, CMAX, CMAX});
    add_path(MODE_BEZIER, 65,  '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    add_path(MODE_BEZIER, 5,   '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    add_path(MODE_BEZIER, 1,   '{12345, -54321, 777, CMAX, CMIN, -1, 1, 0});
    add_path(MODE_BEZIER, 0,   '{-256, 256, -256, CMAX, CMAX, 256, -256, 256});
    add_path(MODE_BEZIER, 7,   '{0, 0, 0, CMAX, CMIN, 0, 0, 0});
    add_path(MODE_BEZIER, 3,   '{0, 0, 0, 1, -1, 0, 1, -1});
    add_path(MODE_LINE,   64,  '{-1, -1, -1, CMIN, CMAX, 0, 0, 0});
    add_path(MODE_BEZIER, 96,  '{CMIN, 0, CMAX, CMAX, 0, CMIN, CMAX, 0});
    add_path(MODE_LINE,   42,  '{-1, 0, CMAX, -1, 0, CMIN, -1, CMIN});
    add_path(MODE_BEZIER, 2,   '{-1, -1, -1, -1, -1, -1, -1, -1});

    for (i = 0; i < NUM_RANDOM; i++) begin
      r = random_path();
      if (i == 0 || i == NUM_RANDOM / 2) r.drain_first = 1'b1;
      append_path(r);
    end
    total_paths = pending_paths.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_paths.size() > 0 || req_valid || !expected_empty) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
